/* hw/rtl/aes_pkg.sv */
`default_nettype none
package aes_pkg;

    localparam logic [3:0] NUM_ROUNDS = 4'd10;
    localparam int         NUM_KEYS   = 11;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_INIT,
        ST_ROUND,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       expand;
        logic       init_add;
        logic       round;
        logic       out_load;
        logic [3:0] cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        logic keys_ready;
        logic out_free;
    } dp_status_t;

    localparam logic [2047:0] SBOX_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_TAB = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    // entry v sits at bit 2047 - 8v, which is {~v, 3'b111}
    function automatic logic [7:0] sbox(input logic [7:0] v);
        return SBOX_TAB[{~v, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        return INV_SBOX_TAB[{~v, 3'b111} -: 8];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of the block lives at bits 127-8n, row n%4, column n/4
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[i*8 +: 8] = inv ? inv_sbox(s[i*8 +: 8]) : sbox(s[i*8 +: 8]);
        end
        return r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                r[127 - 8*(4*c + q) -: 8] = inv ? s[127 - 8*(4*((c - q + 4) % 4) + q) -: 8]
                                                : s[127 - 8*(4*((c + q) % 4) + q) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8*k -: 8];
            x2[k] = xt(a[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        r = '0;
        for (int q = 0; q < 4; q++) begin
            if (inv) begin
                r[31 - 8*q -: 8] = me[q] ^ mb[(q + 1) % 4] ^ md[(q + 2) % 4] ^ m9[(q + 3) % 4];
            end
            else begin
                r[31 - 8*q -: 8] = x2[q] ^ x2[(q + 1) % 4] ^ a[(q + 1) % 4]
                                 ^ a[(q + 2) % 4] ^ a[(q + 3) % 4];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], inv);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/aes_ctrl.sv */
`default_nettype none
module aes_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire aes_pkg::dp_status_t status,
    output aes_pkg::ctrl_cmd_t      cmd
);

    aes_pkg::ctrl_state_t state_reg;
    aes_pkg::ctrl_state_t state_next;
    logic [3:0]           cnt_reg;
    logic [3:0]           cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aes_pkg::ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.keys_ready ? aes_pkg::ST_INIT : aes_pkg::ST_EXPAND;
                    cnt_next   = 4'd1;
                end
            end
            aes_pkg::ST_EXPAND:
            begin
                if (cnt_reg == aes_pkg::NUM_ROUNDS)
                begin
                    state_next = aes_pkg::ST_INIT;
                    cnt_next   = 4'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            aes_pkg::ST_INIT:
            begin
                state_next = aes_pkg::ST_ROUND;
                cnt_next   = 4'd1;
            end
            aes_pkg::ST_ROUND:
            begin
                if (cnt_reg == aes_pkg::NUM_ROUNDS)
                begin
                    state_next = status.out_free ? aes_pkg::ST_IDLE : aes_pkg::ST_HOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            aes_pkg::ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = aes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.cnt      = cnt_reg;
        case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            aes_pkg::ST_EXPAND:
            begin
                cmd.expand = 1'b1;
            end
            aes_pkg::ST_INIT:
            begin
                cmd.init_add = 1'b1;
            end
            aes_pkg::ST_ROUND:
            begin
                cmd.round    = 1'b1;
                cmd.out_load = (cnt_reg == aes_pkg::NUM_ROUNDS) && status.out_free;
            end
            aes_pkg::ST_HOLD:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_round_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> status.keys_ready)
        else $error("round started without expanded keys");

    a_expand_to_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aes_pkg::ST_EXPAND && cnt_reg == aes_pkg::NUM_ROUNDS)
        |=> (state_reg == aes_pkg::ST_INIT && status.keys_ready))
        else $error("expansion did not finish into init");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aes_pkg::ST_ROUND) |-> (cnt_reg >= 4'd1 && cnt_reg <= aes_pkg::NUM_ROUNDS))
        else $error("round counter out of range");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a waiting beat");

endmodule
`default_nettype wire

/* hw/rtl/aes_dp.sv */
`default_nettype none
module aes_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire logic              op,
    input  wire logic [63:0]       block_high,
    input  wire logic [63:0]       block_low,
    input  wire aes_pkg::ctrl_cmd_t cmd,
    output logic                   keys_ready,
    output logic [127:0]           result
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic         keys_ready_reg;
    logic [127:0] exp_reg;
    logic [127:0] exp_next;
    logic [127:0] rk_reg [aes_pkg::NUM_KEYS];
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic         dec_reg;
    logic [3:0]   key_idx;
    logic [127:0] round_key;
    logic [127:0] exp_src;
    logic [31:0]  sub_word;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic [31:0]  w2;
    logic [31:0]  w3;
    logic [127:0] enc_out;
    logic [127:0] dec_out;
    logic [127:0] enc_sr;
    logic [127:0] dec_ak;
    logic         last_round;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= 64'd0;
            key_low_reg    <= 64'd0;
            keys_ready_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == aes_pkg::CFG_KEY_HIGH)
                begin
                    key_high_reg <= cfg_data;
                end
                else
                begin
                    key_low_reg <= cfg_data;
                end
                keys_ready_reg <= 1'b0;
            end
            else if (cmd.expand && cmd.cnt == aes_pkg::NUM_ROUNDS)
            begin
                keys_ready_reg <= 1'b1;
            end
        end
    end

    // one round key per cycle; the previous key is kept apart from the store
    assign exp_src = (cmd.cnt == 4'd1) ? {key_high_reg, key_low_reg} : exp_reg;

    always_comb
    begin
        sub_word = {aes_pkg::sbox(exp_src[23:16]), aes_pkg::sbox(exp_src[15:8]),
                    aes_pkg::sbox(exp_src[7:0]), aes_pkg::sbox(exp_src[31:24])};
        sub_word[31:24] = sub_word[31:24] ^ aes_pkg::rcon(cmd.cnt);
        w0 = exp_src[127:96] ^ sub_word;
        w1 = exp_src[95:64] ^ w0;
        w2 = exp_src[63:32] ^ w1;
        w3 = exp_src[31:0] ^ w2;
        exp_next = {w0, w1, w2, w3};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.expand)
        begin
            exp_reg         <= exp_next;
            rk_reg[cmd.cnt] <= exp_next;
            if (cmd.cnt == 4'd1)
            begin
                rk_reg[0] <= {key_high_reg, key_low_reg};
            end
        end
    end

    always_comb
    begin
        if (cmd.init_add)
        begin
            key_idx = dec_reg ? aes_pkg::NUM_ROUNDS : 4'd0;
        end
        else
        begin
            key_idx = dec_reg ? (aes_pkg::NUM_ROUNDS - cmd.cnt) : cmd.cnt;
        end
    end

    assign round_key  = rk_reg[key_idx];
    assign last_round = (cmd.cnt == aes_pkg::NUM_ROUNDS);

    always_comb
    begin
        enc_sr  = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_reg, 1'b0), 1'b0);
        enc_out = (last_round ? enc_sr : aes_pkg::mix_columns(enc_sr, 1'b0)) ^ round_key;
        dec_ak  = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_reg, 1'b1), 1'b1) ^ round_key;
        dec_out = last_round ? dec_ak : aes_pkg::mix_columns(dec_ak, 1'b1);
    end

    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
        begin
            state_next = {block_high, block_low};
        end
        else if (cmd.init_add)
        begin
            state_next = state_reg ^ round_key;
        end
        else if (cmd.round)
        begin
            state_next = (dec_reg == aes_pkg::OP_DECRYPT) ? dec_out : enc_out;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        if (cmd.load)
        begin
            dec_reg <= op;
        end
    end

    assign keys_ready = keys_ready_reg;
    assign result     = cmd.round ? state_next : state_reg;

endmodule
`default_nettype wire

/* hw/rtl/aes128_block_cipher_top.sv */
`default_nettype none
// channel | signals                        | direction
// input   | in_valid/in_ready, op, block_* | into block
// output  | out_valid/out_ready, out_*     | out of block
// config  | cfg_write, cfg_index, cfg_data | into block, no wait
// a result beat becomes valid after one key add and ten rounds, each round one pass
// through the shared round unit
// the next block can be accepted only after the previous one has gone back to idle
// the first block after reset or a key write first runs key expansion
// reset clears control and the key registers; round keys are rebuilt on demand
// a result waits in the output register; the next block then holds its last round
// and the input stalls until the waiting beat is taken
module aes128_block_cipher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_high,
    output logic [63:0]      out_low
);

    aes_pkg::ctrl_cmd_t  cmd;
    aes_pkg::dp_status_t status;
    logic                keys_ready;
    logic [127:0]        result;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [127:0]        out_data_reg;

    assign status = '{keys_ready: keys_ready, out_free: (!out_valid_reg || out_ready)};

    aes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    aes_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .block_high (block_high),
        .block_low  (block_low),
        .cmd        (cmd),
        .keys_ready (keys_ready),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_high  = out_data_reg[127:64];
    assign out_low   = out_data_reg[63:0];

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        op_bit;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic        known;
        logic [127:0] want;
    } vector_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    aes128_block_cipher_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .block_high (block_high),
        .block_low  (block_low),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_high   (out_high),
        .out_low    (out_low)
    );

    // predictor state
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [31:0]  round_words [44];
    logic         words_valid;
    logic [63:0]  key_hi_m;
    logic [63:0]  key_lo_m;

    logic [127:0] pending_blocks [$];
    int           mismatch_count;
    int           idle_cycles;
    int           hold_len;
    bit           gaps_on;
    bit           stalls_on;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic void build_sboxes();
        logic [7:0] x;
        logic [7:0] y;
        for (int v = 0; v < 256; v++)
        begin
            x = 8'h01;
            for (int k = 0; k < 254; k++)
                x = gf_mul(x, v[7:0]);
            y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                ^ {x[3:0], x[7:4]} ^ 8'h63;
            fwd_tab[v] = y;
            inv_tab[y] = v[7:0];
        end
    endfunction

    function automatic void expand_words();
        logic [31:0] t;
        logic [7:0]  rc;
        round_words[0] = key_hi_m[63:32];
        round_words[1] = key_hi_m[31:0];
        round_words[2] = key_lo_m[63:32];
        round_words[3] = key_lo_m[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = round_words[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]] ^ rc, fwd_tab[t[23:16]], fwd_tab[t[15:8]],
                     fwd_tab[t[7:0]]};
                rc = gf_dbl(rc);
            end
            round_words[i] = round_words[i-4] ^ t;
        end
        words_valid = 1'b1;
    endfunction

    function automatic logic [127:0] aes_block(input logic dec, input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   m [4];
        logic [127:0] res;
        int           rnd;
        if (!words_valid)
            expand_words();
        if (dec)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int n = 0; n < 16; n++)
            s[n] = blk[127 - 8*n -: 8];
        for (int step = 0; step <= 10; step++)
        begin
            rnd = dec ? 10 - step : step;
            if (step > 0)
            begin
                for (int n = 0; n < 16; n++)
                    t[n] = dec ? inv_tab[s[n]] : fwd_tab[s[n]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        s[4*c + r] = dec ? t[4*((c - r + 4) % 4) + r]
                                         : t[4*((c + r) % 4) + r];
                // forward mixes before the key add, inverse after it
                if (!dec && rnd != 10)
                begin
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                        begin
                            s[4*c + r] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                s[4*c + r] ^= gf_mul(m[(k - r + 4) % 4], t[4*c + k]);
                        end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4*c + r] ^= round_words[rnd*4 + c][31 - 8*r -: 8];
            if (dec && step > 0 && rnd != 0)
            begin
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        s[4*c + r] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            s[4*c + r] ^= gf_mul(m[(k - r + 4) % 4], t[4*c + k]);
                    end
            end
        end
        for (int n = 0; n < 16; n++)
            res[127 - 8*n -: 8] = s[n];
        return res;
    endfunction

    task automatic offer_block(input logic o, input logic [63:0] h, input logic [63:0] l,
                               input logic known, input logic [127:0] want);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        op         = o;
        block_high = h;
        block_low  = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_blocks.push_back(known ? want : aes_block(o, {h, l}));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge clk);
        // block is idle once the last beat is out; a few spare cycles anyway
        repeat (4) @(negedge clk);
    endtask

    task automatic write_key(input logic [63:0] h, input logic [63:0] l, input int which);
        drain();
        if (which != 2)
        begin
            cfg_write = 1'b1;
            cfg_index = aes_pkg::CFG_KEY_HIGH;
            cfg_data  = h;
            key_hi_m  = h;
            @(negedge clk);
        end
        if (which != 1)
        begin
            cfg_write = 1'b1;
            cfg_index = aes_pkg::CFG_KEY_LOW;
            cfg_data  = l;
            key_lo_m  = l;
            @(negedge clk);
        end
        cfg_write   = 1'b0;
        words_valid = 1'b0;
    endtask

    // result side
    initial
    begin
        int stall;
        logic [127:0] want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            stall = stalls_on ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_blocks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected beat out_high %h out_low %h", $time, out_high,
                         out_low);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (out_high !== want[127:64])
                begin
                    mismatch_count++;
                    $display("%0t out_high exp %h act %h", $time, want[127:64], out_high);
                end
                if (out_low !== want[63:0])
                begin
                    mismatch_count++;
                    $display("%0t out_low exp %h act %h", $time, want[63:0], out_low);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("aes128_block_cipher_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        vector_row_t rows [$];
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] kh;
        logic [63:0] kl;
        int          pick;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = aes_pkg::CFG_KEY_HIGH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = aes_pkg::OP_ENCRYPT;
        block_high  = '0;
        block_low   = '0;
        idle_cycles = 0;
        hold_len    = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        mismatch_count = 0;
        key_hi_m    = '0;
        key_lo_m    = '0;
        words_valid = 1'b0;
        build_sboxes();

        // key all zero before any write, then the standard key, then all ones
        rows = '{
            '{64'h0, 64'h0, aes_pkg::OP_ENCRYPT, 64'h0, 64'h0, 1'b1,
              128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
            '{64'h0, 64'h0, aes_pkg::OP_DECRYPT,
              64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 128'h0},
            '{64'h0, 64'h0, aes_pkg::OP_ENCRYPT, '1, '1, 1'b0, 128'h0},
            '{64'h0, 64'h0, aes_pkg::OP_DECRYPT, '1, '1, 1'b0, 128'h0},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_ENCRYPT,
              64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
              128'h69c4e0d86a7b0430d8cdb78070b4c55a},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_DECRYPT,
              64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
              128'h00112233445566778899aabbccddeeff},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_ENCRYPT,
              '0, '1, 1'b0, 128'h0},
            '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::OP_DECRYPT,
              '1, '0, 1'b0, 128'h0},
            '{'1, '1, aes_pkg::OP_ENCRYPT, '0, '0, 1'b0, 128'h0},
            '{'1, '1, aes_pkg::OP_DECRYPT, '0, '0, 1'b0, 128'h0},
            '{'1, '1, aes_pkg::OP_ENCRYPT, '1, '1, 1'b0, 128'h0},
            '{'1, '1, aes_pkg::OP_DECRYPT, 64'h8000000000000001, 64'h0123456789abcdef,
              1'b0, 128'h0}
        };

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].key_hi != key_hi_m || rows[i].key_lo != key_lo_m)
                write_key(rows[i].key_hi, rows[i].key_lo, 0);
            offer_block(rows[i].op_bit, rows[i].blk_hi, rows[i].blk_lo, rows[i].known,
                        rows[i].want);
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            pick = $urandom_range(0, 3);
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
            if (phase == 0)
            begin
                kh = '0;
                kl = '0;
            end
            else if (phase == 1)
            begin
                kh = '1;
                kl = '1;
            end
            // sometimes only one half changes, otherwise both halves are written
            write_key(kh, kl, (phase < 2) ? 0 : pick % 3);
            gaps_on   = (phase % 4 != 2);
            stalls_on = (phase % 4 != 3);
            if (phase == 4)
                hold_len = 400;
            for (int n = 0; n < 125; n++)
            begin
                pick = $urandom_range(0, 9);
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
                if (pick == 0)
                begin
                    hi = '0;
                    lo = '0;
                end
                else if (pick == 1)
                begin
                    hi = '1;
                    lo = '1;
                end
                offer_block($urandom_range(0, 1), hi, lo, 1'b0, 128'h0);
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("aes128_block_cipher_top regression: pass");
        else
            $display("aes128_block_cipher_top regression: fail");
        $finish;
    end

endmodule
